// ===== design/ptb_pkg.sv =====
`default_nettype none

package ptb_pkg;

  // channel and divider sizes
  localparam int unsigned NumLanes = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned DivW     = ChanW + 1;
  localparam int unsigned NumCells = ChanW;
  localparam int unsigned PixW     = 32;

  // lane positions
  localparam int unsigned LaneB = 0;
  localparam int unsigned LaneG = 1;
  localparam int unsigned LaneR = 2;

  // pixel formats
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_RGB565      = 2'd0;
  localparam mode_t MODE_ARGB32      = 2'd1;
  localparam mode_t MODE_ARGB_TO_565 = 2'd2;

  // register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TINT_RED   = 3'd0;
  localparam reg_idx_t REG_TINT_GREEN = 3'd1;
  localparam reg_idx_t REG_TINT_BLUE  = 3'd2;
  localparam reg_idx_t REG_TINT_LEVEL = 3'd3;
  localparam reg_idx_t REG_PIXEL_MODE = 3'd4;

  // one channel in the divider: partial remainder and the shared
  // dividend / quotient shift word
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] nq;
  } lane_t;

  // what one cell hands to the next
  typedef struct packed {
    logic                      valid;
    mode_t                     mode;
    logic [DivW-1:0]           divisor;
    lane_t [NumLanes-1:0]      lane;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/pixel_tint_blend.sv =====
// channel   | direction | signals                     | payload
// s_axis    | in        | tvalid tready tdata[31:0]   | src_pixel
// m_axis    | out       | tvalid tready tdata[31:0]   | dst_pixel
// cfg       | in        | we idx[2:0] data[7:0]       | tint_red/green/blue, tint_level, mode
//
// one pixel per cycle sustained while the output is not stalled; a pixel passes the numerator stage,
// eight divider cells (one quotient bit each) and the output register.
// reset clears the valid bits, the skid slot and the registers to
// tint 0, level 2, mode argb32.
// m_axis_tready low with the output slot full freezes the whole chain; a skid slot still takes one
// more request, so s_axis_tready drops in the cycle after that request is taken.
`default_nettype none

module pixel_tint_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] src_pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] dst_pixel
  input  wire logic        cfg_we_i,
  input  wire ptb_pkg::reg_idx_t cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);
  import ptb_pkg::*;

  logic [ChanW-1:0] tint_red_q, tint_green_q, tint_blue_q, tint_level_q;
  mode_t            mode_q;
  logic             skid_q, skid_d;
  logic [PixW-1:0]  skid_data_q;
  logic             en;
  logic             in_valid;
  logic [PixW-1:0]  in_pixel;
  cell_t            chain [NumCells+1];
  logic             m_valid_q;
  logic [PixW-1:0]  m_data_q;
  logic [PixW-1:0]  pack_c;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_red_q   <= '0;
      tint_green_q <= '0;
      tint_blue_q  <= '0;
      tint_level_q <= ChanW'(2);
      mode_q       <= MODE_ARGB32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TINT_RED:   tint_red_q   <= cfg_data_i;
        REG_TINT_GREEN: tint_green_q <= cfg_data_i;
        REG_TINT_BLUE:  tint_blue_q  <= cfg_data_i;
        REG_TINT_LEVEL: tint_level_q <= cfg_data_i;
        REG_PIXEL_MODE: mode_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // chain moves whenever the output slot is free or being drained
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !skid_q;

  // skid slot catches a request taken during a stall
  always_comb begin
    skid_d = skid_q;
    if (en) begin
      skid_d = 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      skid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && !skid_q) begin
      skid_data_q <= s_axis_tdata;
    end
  end

  assign in_valid = skid_q || s_axis_tvalid;
  assign in_pixel = skid_q ? skid_data_q : s_axis_tdata;

  // numerator stage
  ptb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid),
    .pixel_i      (in_pixel),
    .tint_red_i   (tint_red_q),
    .tint_green_i (tint_green_q),
    .tint_blue_i  (tint_blue_q),
    .tint_level_i (tint_level_q),
    .mode_i       (mode_q),
    .cell_o       (chain[0])
  );

  // divider cells, one quotient bit each
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    ptb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // pack quotients into the output format
  always_comb begin
    unique case (chain[NumCells].mode)
      MODE_RGB565: pack_c = {16'h0000,
                             chain[NumCells].lane[LaneR].nq[4:0],
                             chain[NumCells].lane[LaneG].nq[5:0],
                             chain[NumCells].lane[LaneB].nq[4:0]};
      MODE_ARGB32: pack_c = {8'hFF,
                             chain[NumCells].lane[LaneR].nq,
                             chain[NumCells].lane[LaneG].nq,
                             chain[NumCells].lane[LaneB].nq};
      MODE_ARGB_TO_565: pack_c = {16'h0000,
                                  chain[NumCells].lane[LaneR].nq[7:3],
                                  chain[NumCells].lane[LaneG].nq[7:2],
                                  chain[NumCells].lane[LaneB].nq[7:3]};
      default: pack_c = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= chain[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= pack_c;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a finished pixel leaving the last cell lands in the output slot
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && chain[NumCells].valid |=> m_axis_tvalid)
    else $error("last cell result not moved to output");

  // the skid slot empties as soon as the chain moves
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q && en |=> !skid_q)
    else $error("skid slot not drained");

  // a request taken during a stall is held in the skid slot
  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !en |=> skid_q)
    else $error("stalled request not captured");

endmodule

`default_nettype wire

// ===== design/ptb_front.sv =====
`default_nettype none

module ptb_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        in_valid_i,
  input  wire logic [ptb_pkg::PixW-1:0]    pixel_i,
  input  wire logic [ptb_pkg::ChanW-1:0]   tint_red_i,
  input  wire logic [ptb_pkg::ChanW-1:0]   tint_green_i,
  input  wire logic [ptb_pkg::ChanW-1:0]   tint_blue_i,
  input  wire logic [ptb_pkg::ChanW-1:0]   tint_level_i,
  input  wire ptb_pkg::mode_t              mode_i,
  output ptb_pkg::cell_t                   cell_o
);
  import ptb_pkg::*;

  logic [ChanW-1:0]   src_c  [NumLanes];
  logic [ChanW-1:0]   tint_c [NumLanes];
  logic [2*ChanW-1:0] num_c  [NumLanes];
  cell_t              cell_q;

  // pick the channel values; 565 fields are blended as small integers
  always_comb begin
    if (mode_i == MODE_RGB565) begin
      src_c[LaneR]  = {3'b000, pixel_i[15:11]};
      src_c[LaneG]  = {2'b00, pixel_i[10:5]};
      src_c[LaneB]  = {3'b000, pixel_i[4:0]};
      tint_c[LaneR] = {3'b000, tint_red_i[7:3]};
      tint_c[LaneG] = {2'b00, tint_green_i[7:2]};
      tint_c[LaneB] = {3'b000, tint_blue_i[7:3]};
    end else begin
      src_c[LaneR]  = pixel_i[23:16];
      src_c[LaneG]  = pixel_i[15:8];
      src_c[LaneB]  = pixel_i[7:0];
      tint_c[LaneR] = tint_red_i;
      tint_c[LaneG] = tint_green_i;
      tint_c[LaneB] = tint_blue_i;
    end
  end

  // numerator tint * level + source, never above 16 bits
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      num_c[i] = (2*ChanW)'(tint_c[i]) * (2*ChanW)'(tint_level_i) + (2*ChanW)'(src_c[i]);
    end
  end

  // high byte is below the divisor since the quotient fits a byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q.valid   <= in_valid_i;
      cell_q.mode    <= mode_i;
      cell_q.divisor <= {1'b0, tint_level_i} + DivW'(1);
      for (int i = 0; i < NumLanes; i++) begin
        cell_q.lane[i].rem <= num_c[i][2*ChanW-1:ChanW];
        cell_q.lane[i].nq  <= num_c[i][ChanW-1:0];
      end
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== design/ptb_cell.sv =====
`default_nettype none

module ptb_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire ptb_pkg::cell_t  cell_i,
  output ptb_pkg::cell_t       cell_o
);
  import ptb_pkg::*;

  logic [DivW:0]    trial_c [NumLanes];
  logic             take_c  [NumLanes];
  logic [DivW:0]    diff_c  [NumLanes];
  lane_t            lane_d  [NumLanes];
  cell_t            cell_q;

  // one restoring step per lane: shift in the next dividend bit,
  // subtract when it fits, shift the quotient bit into the low end
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      trial_c[i] = {1'b0, cell_i.lane[i].rem, cell_i.lane[i].nq[ChanW-1]};
      take_c[i]  = trial_c[i] >= {1'b0, cell_i.divisor};
      diff_c[i]  = take_c[i] ? (trial_c[i] - {1'b0, cell_i.divisor}) : trial_c[i];
      lane_d[i].rem = diff_c[i][ChanW-1:0];
      lane_d[i].nq  = {cell_i.lane[i].nq[ChanW-2:0], take_c[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q.valid   <= cell_i.valid;
      cell_q.mode    <= cell_i.mode;
      cell_q.divisor <= cell_i.divisor;
      for (int i = 0; i < NumLanes; i++) begin
        cell_q.lane[i] <= lane_d[i];
      end
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire
